// ----- hw/rtl/modular_exponentiation_macros.svh -----
// assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// same-cycle implication, checked out of reset
`define MEXP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mexp_pkg.sv -----
// shared constants and types of the modular exponentiation block
package mexp_pkg;

    // fixed prime modulus and field widths
    localparam longint unsigned MODULUS = 64'd1000000007;
    localparam int IN_W  = 63;
    localparam int EXP_W = 63;
    localparam int RES_W = 30;

    // residue width and multiplier operand/product widths
    localparam int MOD_W = $clog2(MODULUS + 64'd1);
    localparam int OPW   = MOD_W + 2;
    localparam int PW    = 2 * OPW;

    // base is reduced in chunks of MOD_W bits, top chunk first
    localparam int NCH   = (IN_W + MOD_W - 1) / MOD_W;
    localparam int CNT_W = $clog2(NCH + 1);

    // barrett reciprocal floor(2^(2*MOD_W) / MODULUS)
    localparam logic [63:0]      MU_FULL = (64'd1 << (2 * MOD_W)) / MODULUS;
    localparam logic [OPW-1:0]   MU      = MU_FULL[OPW-1:0];
    localparam logic [MOD_W-1:0] ONE_RES = MOD_W'(64'd1 % MODULUS);

    // command to the shared modular multiplier
    typedef struct packed {
        logic               go;
        logic               load;   // reduce p directly instead of a*b
        logic [MOD_W-1:0]   a;
        logic [MOD_W-1:0]   b;
        logic [2*MOD_W-1:0] p;
    } t_mm_cmd;

endpackage

// ----- hw/rtl/mexp_modmul.sv -----
// shared multiplier with barrett reduction: (a*b) mod MODULUS or p mod MODULUS
module mexp_modmul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mexp_pkg::t_mm_cmd             i_cmd,
    output logic                          o_done,
    output logic [mexp_pkg::MOD_W-1:0]    o_res
);
    import mexp_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_Q    = 2'd1;
    localparam logic [1:0] PH_R    = 2'd2;
    localparam logic [1:0] PH_C    = 2'd3;

    localparam logic [OPW-1:0] MOD_X1 = OPW'(MODULUS);
    localparam logic [OPW-1:0] MOD_X2 = OPW'(2 * MODULUS);

    logic [1:0]         r_phase, n_phase;
    logic [2*MOD_W-1:0] r_p;
    logic [PW-1:0]      r_t;
    logic               r_done;
    logic [MOD_W-1:0]   r_res;

    logic [OPW-1:0]     op_a, op_b;
    logic [PW-1:0]      prod;
    logic [OPW-1:0]     diff, diff_m1, diff_m2, fixed;

    // operand select for the single multiplier
    always_comb begin
        unique case (r_phase)
            PH_IDLE: begin
                op_a = OPW'(i_cmd.a);
                op_b = OPW'(i_cmd.b);
            end
            PH_Q: begin
                op_a = OPW'(r_p[2*MOD_W-1:MOD_W-1]);
                op_b = MU;
            end
            PH_R: begin
                op_a = OPW'(r_t[2*MOD_W+1:MOD_W+1]);
                op_b = MOD_X1;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b;

    // remainder estimate is below 3*MODULUS, fold it down
    always_comb begin
        diff    = r_p[OPW-1:0] - r_t[OPW-1:0];
        diff_m1 = diff - MOD_X1;
        diff_m2 = diff - MOD_X2;
        if (diff >= MOD_X2) begin
            fixed = diff_m2;
        end else if (diff >= MOD_X1) begin
            fixed = diff_m1;
        end else begin
            fixed = diff;
        end
    end

    // phase sequence
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_cmd.go) begin
                    n_phase = PH_Q;
                end
            end
            PH_Q:    n_phase = PH_R;
            PH_R:    n_phase = PH_C;
            default: n_phase = PH_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == PH_C);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE && i_cmd.go) begin
            r_p <= i_cmd.load ? i_cmd.p : prod[2*MOD_W-1:0];
        end
        if (r_phase == PH_Q || r_phase == PH_R) begin
            r_t <= prod;
        end
        if (r_phase == PH_C) begin
            r_res <= fixed[MOD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- hw/rtl/modular_exponentiation.sv -----
// modular exponentiation top level: sequencer around one shared modular multiplier
//
// Computes power_result = base_value ^ exponent mod 1000000007.
// Input: raise start with i_base_value and i_exponent; the item is taken at
// the clock edge where start is high and busy is low. busy stays high until
// the result has been issued; start is ignored while busy.
// Output: o_power_result is valid for exactly one cycle, marked by o_valid.
// There is no backpressure; the receiver must take it in that cycle.
// Sequence: the base is first reduced in 3 chunks of 30 bits, top chunk first,
// then each exponent bit from the low end costs a squaring and a multiply
// when the bit is set, the last set bit skipping its squaring. A zero
// exponent gives o_valid straight after the base reduction.
// busy is already low in the o_valid cycle, so the next item can be taken
// at the edge that ends it; one item at a time.
// Every step goes through the one modular multiplier (multiply, barrett
// quotient, quotient times modulus, correction).
// Reset (synchronous, active low) returns the block to idle, drops busy and
// discards any item in progress without issuing a result.

`include "modular_exponentiation_macros.svh"

module modular_exponentiation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mexp_pkg::IN_W-1:0]     i_base_value,
    input  logic [mexp_pkg::IN_W-1:0]     i_exponent,
    output logic                          o_valid,
    output logic [mexp_pkg::RES_W-1:0]    o_power_result
);
    import mexp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RED   = 3'd1;
    localparam logic [2:0] S_RED_W = 3'd2;
    localparam logic [2:0] S_BIT   = 3'd3;
    localparam logic [2:0] S_MUL_W = 3'd4;
    localparam logic [2:0] S_SQ    = 3'd5;
    localparam logic [2:0] S_SQ_W  = 3'd6;

    localparam logic [CNT_W-1:0] LAST_CHUNK = CNT_W'(NCH - 1);

    logic [2:0]           r_state, n_state;
    logic [NCH*MOD_W-1:0] r_x, n_x;
    logic [MOD_W-1:0]     r_base, n_base;
    logic [MOD_W-1:0]     r_acc, n_acc;
    logic [EXP_W-1:0]     r_exp, n_exp;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_valid, n_valid;
    logic [RES_W-1:0]     r_result, n_result;

    t_mm_cmd              mm_cmd;
    logic                 mm_done;
    logic [MOD_W-1:0]     mm_res;
    logic                 exp_last;

    assign exp_last = ((r_exp >> 1) == '0);

    // shared modular multiplier
    mexp_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mm_cmd),
        .o_done  (mm_done),
        .o_res   (mm_res)
    );

    // sequencer: base reduction, then square-and-multiply from the low bit up
    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_base   = r_base;
        n_acc    = r_acc;
        n_exp    = r_exp;
        n_cnt    = r_cnt;
        n_valid  = 1'b0;
        n_result = r_result;
        mm_cmd.go   = 1'b0;
        mm_cmd.load = 1'b0;
        mm_cmd.a    = r_base;
        mm_cmd.b    = r_base;
        mm_cmd.p    = {r_base, r_x[NCH*MOD_W-1 -: MOD_W]};
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_x     = (NCH*MOD_W)'(i_base_value);
                    n_exp   = i_exponent[EXP_W-1:0];
                    n_base  = '0;
                    n_acc   = ONE_RES;
                    n_cnt   = '0;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                // horner step: (partial * 2^MOD_W + chunk) mod MODULUS
                mm_cmd.go   = 1'b1;
                mm_cmd.load = 1'b1;
                n_x         = r_x << MOD_W;
                n_state     = S_RED_W;
            end
            S_RED_W: begin
                if (mm_done) begin
                    n_base = mm_res;
                    n_cnt  = r_cnt + 1'b1;
                    n_state = (r_cnt == LAST_CHUNK) ? S_BIT : S_RED;
                end
            end
            S_BIT: begin
                if (r_exp == '0) begin
                    n_valid  = 1'b1;
                    n_result = RES_W'(r_acc);
                    n_state  = S_IDLE;
                end else if (r_exp[0]) begin
                    mm_cmd.go = 1'b1;
                    mm_cmd.a  = r_acc;
                    n_state   = S_MUL_W;
                end else begin
                    mm_cmd.go = 1'b1;
                    n_state   = S_SQ_W;
                end
            end
            S_MUL_W: begin
                if (mm_done) begin
                    n_acc = mm_res;
                    if (exp_last) begin
                        // no higher bits: the final squaring is not needed
                        n_valid  = 1'b1;
                        n_result = RES_W'(mm_res);
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_SQ;
                    end
                end
            end
            S_SQ: begin
                mm_cmd.go = 1'b1;
                n_state   = S_SQ_W;
            end
            S_SQ_W: begin
                if (mm_done) begin
                    n_base  = mm_res;
                    n_exp   = r_exp >> 1;
                    n_state = S_BIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_base   <= n_base;
        r_acc    <= n_acc;
        r_exp    <= n_exp;
        r_cnt    <= n_cnt;
        r_result <= n_result;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_power_result = r_result;

    // checks
    `MEXP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `MEXP_ASSERT_IMPL(a_valid_idle, o_valid, !busy, "result issued while still busy")
    `MEXP_ASSERT_IMPL(a_result_range, o_valid, 64'(o_power_result) < MODULUS, "result not reduced")
    `MEXP_ASSERT_IMPL(a_done_waiting, mm_done, (r_state == S_RED_W) || (r_state == S_MUL_W) || (r_state == S_SQ_W), "multiplier finished with no step pending")

endmodule

// ----- tb/modular_exponentiation_tb.sv -----
// testbench for the modular exponentiation block: random and corner items checked against a predictor
module modular_exponentiation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 4;
    localparam int RST_CYCLES   = 7;
    localparam int MAX_ITEMS    = 1024;
    localparam int RANDOM_ITEMS = 650;
    localparam int TAIL_CYCLES  = 700;
    localparam int CYCLE_LIMIT  = 2000000;

    localparam int OPND_W = mexp_pkg::IN_W;
    localparam int POW_W  = mexp_pkg::RES_W;
    localparam logic [OPND_W-1:0] PRIME  = OPND_W'(mexp_pkg::MODULUS);
    localparam logic [OPND_W-1:0] ALL_1S = {OPND_W{1'b1}};

    // one pending item and the idle cycles drawn before it
    typedef struct {
        logic [OPND_W-1:0] base;
        logic [OPND_W-1:0] expo;
        int unsigned       gap;
    } t_pow_item;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic [OPND_W-1:0] i_base_value = '0;
    logic [OPND_W-1:0] i_exponent   = '0;
    logic              busy;
    logic              o_valid;
    logic [POW_W-1:0]  o_power_result;

    t_pow_item        pending_items[$];
    logic [POW_W-1:0] power_expect [0:MAX_ITEMS-1];
    int               n_issued  = 0;
    int               n_checked = 0;
    int               n_errors  = 0;
    int unsigned      gap_left  = 0;
    int               cycle_count = 0;
    bit               no_idle   = 1'b0;

    modular_exponentiation dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .o_valid        (o_valid),
        .o_power_result (o_power_result)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // reset, held at the start only
    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic logic [OPND_W-1:0] rand63();
        return OPND_W'({$urandom, $urandom});
    endfunction

    // base^expo mod prime, right-to-left square and multiply
    function automatic logic [POW_W-1:0] power_mod(logic [OPND_W-1:0] base,
                                                   logic [OPND_W-1:0] expo);
        longint unsigned m;
        longint unsigned sq;
        longint unsigned acc;
        longint unsigned e;
        m   = mexp_pkg::MODULUS;
        sq  = 64'(base) % m;
        acc = 64'd1 % m;
        e   = 64'(expo);
        while (e != 0) begin
            if (e[0])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            e  = e >> 1;
        end
        return POW_W'(acc);
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        n_errors++;
    endtask

    // queue an item, with bursts that never idle
    task automatic add_item(logic [OPND_W-1:0] base, logic [OPND_W-1:0] expo);
        t_pow_item it;
        if ($urandom_range(0, 39) == 0)
            no_idle = ~no_idle;
        it.base = base;
        it.expo = expo;
        it.gap  = no_idle ? 0 : $urandom_range(0, 8);
        pending_items.push_back(it);
    endtask

    // driver: present items, predict on accept, junk on the ports while idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (start && !busy) begin
            power_expect[n_issued % MAX_ITEMS] <= power_mod(i_base_value, i_exponent);
            n_issued <= n_issued + 1;
            if (pending_items.size() != 0 && pending_items[0].gap == 0) begin
                i_base_value <= pending_items[0].base;
                i_exponent   <= pending_items[0].expo;
                void'(pending_items.pop_front());
            end else begin
                start        <= 1'b0;
                gap_left     <= (pending_items.size() != 0) ? pending_items[0].gap - 1 : 0;
                i_base_value <= rand63();
                i_exponent   <= rand63();
            end
        end else if (!start) begin
            if (gap_left != 0) begin
                gap_left     <= gap_left - 1;
                i_base_value <= rand63();
                i_exponent   <= rand63();
            end else if (pending_items.size() != 0) begin
                i_base_value <= pending_items[0].base;
                i_exponent   <= pending_items[0].expo;
                start        <= 1'b1;
                void'(pending_items.pop_front());
            end
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (n_checked >= n_issued) begin
                report_mismatch($sformatf("result %0d with no item outstanding",
                                          o_power_result));
            end else begin
                if (o_power_result !== power_expect[n_checked % MAX_ITEMS])
                    report_mismatch($sformatf("item %0d power_result %0d, predicted %0d",
                                              n_checked, o_power_result,
                                              power_expect[n_checked % MAX_ITEMS]));
                n_checked <= n_checked + 1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("modular_exponentiation_tb: FAIL");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned bsel;
        int unsigned esel;
        int unsigned len;
        logic [OPND_W-1:0] b;
        logic [OPND_W-1:0] e;

        // corner items
        add_item('0, '0);
        add_item(PRIME, '0);
        add_item(ALL_1S, '0);
        add_item('0, 63'd1);
        add_item('0, ALL_1S);
        add_item(ALL_1S, ALL_1S);
        add_item(63'd1, ALL_1S);
        add_item(PRIME, 63'd5);
        add_item(PRIME - 1, 63'd2);
        add_item(PRIME - 1, 63'd3);
        add_item(PRIME + 1, ALL_1S);
        add_item(63'd2, PRIME - 1);
        add_item(63'd2, 63'd1);
        add_item(63'd2, 63'd1 << 62);
        add_item(PRIME * 2, 63'd7);
        add_item(63'd1 << 62, 63'd1);
        add_item(ALL_1S, 63'd1);
        add_item(63'd3, 63'h5555_5555_5555_5555);
        add_item(63'h2AAA_AAAA_AAAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA);
        add_item(63'd1, '0);

        // random items, mostly short exponents
        repeat (RANDOM_ITEMS) begin
            bsel = $urandom_range(0, 99);
            esel = $urandom_range(0, 99);
            if (bsel < 10)
                b = OPND_W'($urandom_range(0, 3));
            else if (bsel < 20)
                b = PRIME * OPND_W'($urandom) + OPND_W'($urandom_range(0, 2));
            else if (bsel < 30)
                b = PRIME - 1 - OPND_W'($urandom_range(0, 3));
            else if (bsel < 40)
                b = OPND_W'($urandom);
            else
                b = rand63();
            if (esel < 5) begin
                e = '0;
            end else begin
                if (esel < 62)
                    len = $urandom_range(1, 16);
                else if (esel < 90)
                    len = $urandom_range(17, 40);
                else
                    len = $urandom_range(41, 63);
                e = rand63() & (ALL_1S >> (OPND_W - len));
                e[len-1] = 1'b1;
            end
            add_item(b, e);
        end

        // wait for every item to be taken and answered
        while (pending_items.size() != 0 || start || !i_rst_n)
            @(posedge i_clk);
        while (n_checked != n_issued)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_checked != n_issued)
            report_mismatch($sformatf("%0d results never arrived", n_issued - n_checked));
        if (n_errors == 0) begin
            $display("modular_exponentiation_tb: PASS");
        end else begin
            $display("modular_exponentiation_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_modmul.sv
hw/rtl/modular_exponentiation.sv
tb/modular_exponentiation_tb.sv
